@@ hdl/sisc_pkg.sv @@
// sisc_pkg: shared types and constants of the stereo matching cost block
// used by sisc_side and sampling_insensitive_stereo_cost_top; no dependencies
`default_nettype none

package sisc_pkg;

   // pixel and item field widths
   localparam int PIXEL_BITS    = 8;
   localparam int PORT_PIX_BITS = 8;
   localparam int HALF_BITS     = PIXEL_BITS + 1;
   localparam int DISP_BITS     = 8;
   localparam int COL_BITS      = 12;
   localparam int WIDTH_BITS    = 13;
   localparam int COST_BITS     = 6;

   // configuration port
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 1'b0,
      CSR_MAX_DISPARITY = 1'b1
   } csr_index_type;

   // register reset values
   localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RESET   = WIDTH_BITS'(640);
   localparam logic [DISP_BITS-1:0]  MAX_DISPARITY_RESET = DISP_BITS'(63);

   // cost clamp, 20.0 grey levels in half units
   localparam logic [COST_BITS-1:0] COST_CLAMP_HALF = COST_BITS'(40);

   // which neighbours of an image position exist
   typedef struct packed {
      logic has_prev;
      logic has_next;
   } sisc_nbr_type;

   // outcome of one side of the measure
   typedef struct packed {
      logic                 hit;
      logic [HALF_BITS-1:0] distance;
   } sisc_side_type;

endpackage

`default_nettype wire

@@ hdl/sisc_side.sv @@
// sisc_side: one direction of the sampling-insensitive dissimilarity
// distance from a centre to the other image's centre and half-samples
// depends on sisc_pkg
`default_nettype none

module sisc_side (
   input  wire logic [sisc_pkg::HALF_BITS-1:0]  own2,
   input  wire logic [sisc_pkg::HALF_BITS-1:0]  oc2,
   input  wire logic [sisc_pkg::PIXEL_BITS-1:0] op,
   input  wire logic [sisc_pkg::PIXEL_BITS-1:0] on,
   input  wire sisc_pkg::sisc_nbr_type          nbr,
   output sisc_pkg::sisc_side_type              res
);

   localparam int HB = sisc_pkg::HALF_BITS;

   function automatic logic [HB-1:0] absdiff(input logic [HB-1:0] a, input logic [HB-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

   // b lies inclusively between a and c
   function automatic logic between(input logic [HB-1:0] a, input logic [HB-1:0] b,
                                    input logic [HB-1:0] c);
      between = !((b > a) && (b > c)) && !((b < a) && (b < c));
   endfunction

   logic [HB-1:0] half_n;
   logic [HB-1:0] half_p;
   logic [HB-1:0] dist_c;
   logic [HB-1:0] dist_n;
   logic [HB-1:0] dist_p;
   logic [HB-1:0] best;

   // half-sample averages in half units
   assign half_n = {1'b0, oc2[HB-1:1]} + {1'b0, on};
   assign half_p = {1'b0, oc2[HB-1:1]} + {1'b0, op};

   assign dist_c = absdiff(own2, oc2);
   assign dist_n = absdiff(own2, half_n);
   assign dist_p = absdiff(own2, half_p);

   // minimum over the centre and the existing half-samples
   always_comb begin
      best = dist_c;
      if (nbr.has_next && (dist_n < best)) begin
         best = dist_n;
      end
      if (nbr.has_prev && (dist_p < best)) begin
         best = dist_p;
      end
   end

   assign res.hit      = (nbr.has_next && between(half_n, own2, oc2)) ||
                         (nbr.has_prev && between(half_p, own2, oc2));
   assign res.distance = best;

endmodule

`default_nettype wire

@@ hdl/sampling_insensitive_stereo_cost_top.sv @@
// sampling_insensitive_stereo_cost_top: per-pixel stereo matching cost
// input register, cost logic and result register; depends on sisc_pkg, sisc_side
`default_nettype none

// Usage
// - request channel: an item is taken at a rising edge with start high and
//   busy low; busy is always low, so one item may be taken every cycle
// - the item carries disparity, left column and three left and three right
//   grey pixels around the left pixel and its right-image match
// - result channel: rsp_valid strobes for one cycle with rsp_cost_half
//   (half grey levels, 0..40) and rsp_out_of_range; it cannot be held off
// - the accepting edge loads the input register; the result register, loaded
//   from it through the cost logic, drives the result channel
// - throughput is one item per cycle, set by the single pass of cost logic
//   between the two registers
// - configuration: csr_we writes csr_wdata to register csr_index
//   (image_width, max_disparity); write only while no item is in flight
// - reset (synchronous, active high) drops any item in flight and restores
//   image_width 640 and max_disparity 63

module sampling_insensitive_stereo_cost_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [sisc_pkg::DISP_BITS-1:0]       req_disparity,
   input  wire logic [sisc_pkg::COL_BITS-1:0]        req_column,
   input  wire logic [sisc_pkg::PORT_PIX_BITS-1:0]   req_left_center,
   input  wire logic [sisc_pkg::PORT_PIX_BITS-1:0]   req_left_prev,
   input  wire logic [sisc_pkg::PORT_PIX_BITS-1:0]   req_left_next,
   input  wire logic [sisc_pkg::PORT_PIX_BITS-1:0]   req_right_match,
   input  wire logic [sisc_pkg::PORT_PIX_BITS-1:0]   req_right_prev,
   input  wire logic [sisc_pkg::PORT_PIX_BITS-1:0]   req_right_next,
   output logic                                      rsp_valid,
   output logic [sisc_pkg::COST_BITS-1:0]            rsp_cost_half,
   output logic                                      rsp_out_of_range,
   input  wire logic                                 csr_we,
   input  wire logic [sisc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [sisc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int PB = sisc_pkg::PIXEL_BITS;
   localparam int HB = sisc_pkg::HALF_BITS;
   localparam int DB = sisc_pkg::DISP_BITS;
   localparam int CB = sisc_pkg::COL_BITS;
   localparam int WB = sisc_pkg::WIDTH_BITS;
   localparam int KB = sisc_pkg::COST_BITS;

   // configuration registers
   logic [WB-1:0] width_ff;
   logic [DB-1:0] max_disp_ff;

   // input register
   logic          valid_ff;
   logic [DB-1:0] disp_ff;
   logic [CB-1:0] col_ff;
   logic [PB-1:0] lc_ff, lp_ff, ln_ff, rc_ff, rp_ff, rn_ff;

   // result register
   logic          rsp_valid_ff;
   logic [KB-1:0] rsp_cost_ff;
   logic          rsp_oor_ff;

   logic          accept;
   logic          oor;
   logic [CB-1:0] q;
   sisc_pkg::sisc_nbr_type  lnbr, rnbr;
   sisc_pkg::sisc_side_type fwd, rev;
   logic [HB-1:0] dmin;
   logic [KB-1:0] cost_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= sisc_pkg::IMAGE_WIDTH_RESET;
         max_disp_ff <= sisc_pkg::MAX_DISPARITY_RESET;
      end else if (csr_we) begin
         case (sisc_pkg::csr_index_type'(csr_index))
            sisc_pkg::CSR_IMAGE_WIDTH:   width_ff    <= csr_wdata[WB-1:0];
            sisc_pkg::CSR_MAX_DISPARITY: max_disp_ff <= csr_wdata[DB-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         disp_ff <= req_disparity;
         col_ff  <= req_column;
         lc_ff   <= req_left_center[PB-1:0];
         lp_ff   <= req_left_prev[PB-1:0];
         ln_ff   <= req_left_next[PB-1:0];
         rc_ff   <= req_right_match[PB-1:0];
         rp_ff   <= req_right_prev[PB-1:0];
         rn_ff   <= req_right_next[PB-1:0];
      end
   end

   // range check and matched column
   assign oor = (disp_ff > max_disp_ff) || (col_ff < CB'(disp_ff));
   assign q   = col_ff - CB'(disp_ff);

   // image edges; the left edge wins when a position is at both
   always_comb begin
      rnbr = '{has_prev: 1'b1, has_next: 1'b1};
      if (q == '0) begin
         rnbr.has_prev = 1'b0;
      end else if ((WB'(q) + WB'(1)) == width_ff) begin
         rnbr.has_next = 1'b0;
      end
      lnbr = '{has_prev: 1'b1, has_next: 1'b1};
      if (col_ff == '0) begin
         lnbr.has_prev = 1'b0;
      end else if ((WB'(col_ff) + WB'(1)) == width_ff) begin
         lnbr.has_next = 1'b0;
      end
   end

   // forward: left centre against the right image
   sisc_side u_fwd (
      .own2 ({lc_ff, 1'b0}),
      .oc2  ({rc_ff, 1'b0}),
      .op   (rp_ff),
      .on   (rn_ff),
      .nbr  (rnbr),
      .res  (fwd)
   );

   // reverse: right centre against the left image
   sisc_side u_rev (
      .own2 ({rc_ff, 1'b0}),
      .oc2  ({lc_ff, 1'b0}),
      .op   (lp_ff),
      .on   (ln_ff),
      .nbr  (lnbr),
      .res  (rev)
   );

   // smaller distance, clamped
   assign dmin = (fwd.distance < rev.distance) ? fwd.distance : rev.distance;

   always_comb begin
      if (oor || fwd.hit || rev.hit) begin
         cost_in = '0;
      end else if (dmin > HB'(sisc_pkg::COST_CLAMP_HALF)) begin
         cost_in = sisc_pkg::COST_CLAMP_HALF;
      end else begin
         cost_in = dmin[KB-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         rsp_cost_ff <= cost_in;
         rsp_oor_ff  <= oor;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cost_half    = rsp_cost_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // checks
   a_cost_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cost_half <= sisc_pkg::COST_CLAMP_HALF))
      else $error("cost above clamp");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_cost_half == '0))
      else $error("out of range item with nonzero cost");

   a_item_flows: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> rsp_valid)
      else $error("registered item produced no result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result without an accepted item");

endmodule

`default_nettype wire

@@ tb/sampling_insensitive_stereo_cost_top_tb.sv @@
// sampling_insensitive_stereo_cost_top_tb: self-checking bench for the stereo matching cost
// block; a queue-fed driver, a strobe monitor and a built-in cost predictor
// depends on sisc_pkg and sampling_insensitive_stereo_cost_top

module sampling_insensitive_stereo_cost_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 8;

   // one pixel/disparity pair as it sits on the request ports
   typedef struct packed {
      logic [sisc_pkg::DISP_BITS-1:0]     disparity;
      logic [sisc_pkg::COL_BITS-1:0]      column;
      logic [sisc_pkg::PORT_PIX_BITS-1:0] left_center;
      logic [sisc_pkg::PORT_PIX_BITS-1:0] left_prev;
      logic [sisc_pkg::PORT_PIX_BITS-1:0] left_next;
      logic [sisc_pkg::PORT_PIX_BITS-1:0] right_match;
      logic [sisc_pkg::PORT_PIX_BITS-1:0] right_prev;
      logic [sisc_pkg::PORT_PIX_BITS-1:0] right_next;
   } pixel_pair_type;

   // predicted result of one pair
   typedef struct packed {
      logic [sisc_pkg::COST_BITS-1:0] cost_half;
      logic                           out_of_range;
   } pair_cost_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [sisc_pkg::DISP_BITS-1:0]     req_disparity = '0;
   logic [sisc_pkg::COL_BITS-1:0]      req_column = '0;
   logic [sisc_pkg::PORT_PIX_BITS-1:0] req_left_center = '0;
   logic [sisc_pkg::PORT_PIX_BITS-1:0] req_left_prev = '0;
   logic [sisc_pkg::PORT_PIX_BITS-1:0] req_left_next = '0;
   logic [sisc_pkg::PORT_PIX_BITS-1:0] req_right_match = '0;
   logic [sisc_pkg::PORT_PIX_BITS-1:0] req_right_prev = '0;
   logic [sisc_pkg::PORT_PIX_BITS-1:0] req_right_next = '0;
   logic                               rsp_valid;
   logic [sisc_pkg::COST_BITS-1:0]     rsp_cost_half;
   logic                               rsp_out_of_range;
   logic                               csr_we = 1'b0;
   sisc_pkg::csr_index_type            csr_index = sisc_pkg::CSR_IMAGE_WIDTH;
   logic [sisc_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   // register copies used by the predictor
   logic [sisc_pkg::WIDTH_BITS-1:0]    width_now = sisc_pkg::IMAGE_WIDTH_RESET;
   logic [sisc_pkg::DISP_BITS-1:0]     max_disp_now = sisc_pkg::MAX_DISPARITY_RESET;

   pixel_pair_type           pixel_pairs[$];
   pair_cost_type            costs_pending[$];
   pixel_pair_type           on_ports;
   pair_cost_type            due;
   bit                       gaps_on = 1'b1;
   int                       mismatches = 0;
   int                       cycle_count = 0;

   sampling_insensitive_stereo_cost_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_disparity    (req_disparity),
      .req_column       (req_column),
      .req_left_center  (req_left_center),
      .req_left_prev    (req_left_prev),
      .req_left_next    (req_left_next),
      .req_right_match  (req_right_match),
      .req_right_prev   (req_right_prev),
      .req_right_next   (req_right_next),
      .rsp_valid        (rsp_valid),
      .rsp_cost_half    (rsp_cost_half),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // absolute difference in half units
   function automatic logic [sisc_pkg::HALF_BITS-1:0] abs_gap(
         input logic [sisc_pkg::HALF_BITS-1:0] a,
         input logic [sisc_pkg::HALF_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // b lies inclusively between a and c
   function automatic logic between(input logic [sisc_pkg::HALF_BITS-1:0] a,
                                    input logic [sisc_pkg::HALF_BITS-1:0] b,
                                    input logic [sisc_pkg::HALF_BITS-1:0] c);
      if (b > a && b > c) return 1'b0;
      if (b < a && b < c) return 1'b0;
      return 1'b1;
   endfunction

   // one direction: returns 1 when own centre falls in a half-sample interval,
   // else gives the closest distance to the other centre or its half-samples
   function automatic logic half_sample_hit(
         input logic [sisc_pkg::HALF_BITS-1:0]  own2,
         input logic [sisc_pkg::HALF_BITS-1:0]  other2,
         input logic [sisc_pkg::PIXEL_BITS-1:0] other_prev,
         input logic [sisc_pkg::PIXEL_BITS-1:0] other_next,
         input logic                            has_prev,
         input logic                            has_next,
         output logic [sisc_pkg::HALF_BITS-1:0] distance);
      logic [sisc_pkg::HALF_BITS-1:0] half;
      logic [sisc_pkg::HALF_BITS-1:0] best;
      best = abs_gap(own2, other2);
      distance = best;
      if (has_next) begin
         half = {1'b0, other2[sisc_pkg::HALF_BITS-1:1]} + {1'b0, other_next};
         if (between(half, own2, other2)) return 1'b1;
         if (abs_gap(own2, half) < best) best = abs_gap(own2, half);
      end
      if (has_prev) begin
         half = {1'b0, other2[sisc_pkg::HALF_BITS-1:1]} + {1'b0, other_prev};
         if (between(half, own2, other2)) return 1'b1;
         if (abs_gap(own2, half) < best) best = abs_gap(own2, half);
      end
      distance = best;
      return 1'b0;
   endfunction

   // expected dissimilarity of a pair under the current registers
   function automatic pair_cost_type pair_cost(input pixel_pair_type p);
      pair_cost_type                  r;
      logic [sisc_pkg::COL_BITS-1:0]  q;
      logic                           l_prev, l_next, r_prev, r_next;
      logic [sisc_pkg::HALF_BITS-1:0] fwd, rev, best;
      r = '0;
      if (p.disparity > max_disp_now || p.column < p.disparity) begin
         r.out_of_range = 1'b1;
         return r;
      end
      q = p.column - sisc_pkg::COL_BITS'(p.disparity);
      // left edge wins over right edge
      r_prev = (q != 0);
      r_next = (q == 0) || ({1'b0, q} + 13'd1 != width_now);
      l_prev = (p.column != 0);
      l_next = (p.column == 0) || ({1'b0, p.column} + 13'd1 != width_now);
      if (half_sample_hit({p.left_center, 1'b0}, {p.right_match, 1'b0},
                          p.right_prev, p.right_next, r_prev, r_next, fwd)) return r;
      if (half_sample_hit({p.right_match, 1'b0}, {p.left_center, 1'b0},
                          p.left_prev, p.left_next, l_prev, l_next, rev)) return r;
      best = (fwd < rev) ? fwd : rev;
      if (best > sisc_pkg::HALF_BITS'(sisc_pkg::COST_CLAMP_HALF)) begin
         best = sisc_pkg::HALF_BITS'(sisc_pkg::COST_CLAMP_HALF);
      end
      r.cost_half = best[sisc_pkg::COST_BITS-1:0];
      return r;
   endfunction

   // grey value near a base, clipped to the pixel range
   function automatic logic [7:0] jitter(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // random pair biased toward image edges, q at zero and smooth pixel runs
   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      int             w, d, base, shift;
      w = int'(width_now);
      if ($urandom_range(0, 4) == 0) begin
         p.disparity = sisc_pkg::DISP_BITS'($urandom_range(0, 255));
      end else begin
         p.disparity = sisc_pkg::DISP_BITS'($urandom_range(0, int'(max_disp_now)));
      end
      d = int'(p.disparity);
      case ($urandom_range(0, 9))
         0: p.column = sisc_pkg::COL_BITS'(d);
         1: p.column = '0;
         2: p.column = sisc_pkg::COL_BITS'(w - 1);
         3: p.column = sisc_pkg::COL_BITS'(d + w - 1);
         4: p.column = sisc_pkg::COL_BITS'($urandom_range(0, d));
         5: p.column = sisc_pkg::COL_BITS'($urandom);
         default: p.column = sisc_pkg::COL_BITS'(d + $urandom_range(0, (w > 1) ? w - 1 : 0));
      endcase
      base = $urandom_range(0, 255);
      case ($urandom_range(0, 2))
         0: begin
            p.left_center = sisc_pkg::PORT_PIX_BITS'($urandom);
            p.left_prev   = sisc_pkg::PORT_PIX_BITS'($urandom);
            p.left_next   = sisc_pkg::PORT_PIX_BITS'($urandom);
            p.right_match = sisc_pkg::PORT_PIX_BITS'($urandom);
            p.right_prev  = sisc_pkg::PORT_PIX_BITS'($urandom);
            p.right_next  = sisc_pkg::PORT_PIX_BITS'($urandom);
         end
         1: begin
            p.left_center = jitter(base, 6);  p.left_prev = jitter(base, 6);
            p.left_next = jitter(base, 6);    p.right_match = jitter(base, 6);
            p.right_prev = jitter(base, 6);   p.right_next = jitter(base, 6);
         end
         default: begin
            shift = base + int'($urandom_range(0, 120)) - 60;
            p.left_center = jitter(base, 4);  p.left_prev = jitter(base, 10);
            p.left_next = jitter(base, 10);   p.right_match = jitter(shift, 4);
            p.right_prev = jitter(shift, 10); p.right_next = jitter(shift, 10);
         end
      endcase
      return p;
   endfunction

   function automatic void add_pair(input int d, input int col, input int lc, input int lp,
                                    input int ln, input int rc, input int rp, input int rn);
      pixel_pair_type p;
      p.disparity   = sisc_pkg::DISP_BITS'(d);
      p.column      = sisc_pkg::COL_BITS'(col);
      p.left_center = sisc_pkg::PORT_PIX_BITS'(lc);
      p.left_prev   = sisc_pkg::PORT_PIX_BITS'(lp);
      p.left_next   = sisc_pkg::PORT_PIX_BITS'(ln);
      p.right_match = sisc_pkg::PORT_PIX_BITS'(rc);
      p.right_prev  = sisc_pkg::PORT_PIX_BITS'(rp);
      p.right_next  = sisc_pkg::PORT_PIX_BITS'(rn);
      pixel_pairs.push_back(p);
   endfunction

   // register write, only while nothing is in flight
   task automatic set_register(input sisc_pkg::csr_index_type which, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= sisc_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (which == sisc_pkg::CSR_IMAGE_WIDTH) width_now = sisc_pkg::WIDTH_BITS'(value);
      else max_disp_now = sisc_pkg::DISP_BITS'(value);
   endtask

   // wait until every queued item is taken and every result has come back
   task automatic settle();
      @(negedge clock);
      while (pixel_pairs.size() != 0 || start || costs_pending.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int width, input int max_disp, input int count,
                            input bit gaps);
      set_register(sisc_pkg::CSR_IMAGE_WIDTH, width);
      set_register(sisc_pkg::CSR_MAX_DISPARITY, max_disp);
      @(negedge clock);
      gaps_on = gaps;
      repeat (count) pixel_pairs.push_back(random_pair());
      settle();
   endtask

   // driver: take the next item from the queue, with random gaps while gaps_on is set
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         // item accepted at this edge
         if (start) begin
            costs_pending.push_back(pair_cost(on_ports));
         end
         if (pixel_pairs.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 35)) begin
            on_ports = pixel_pairs.pop_front();
            req_disparity   <= on_ports.disparity;
            req_column      <= on_ports.column;
            req_left_center <= on_ports.left_center;
            req_left_prev   <= on_ports.left_prev;
            req_left_next   <= on_ports.left_next;
            req_right_match <= on_ports.right_match;
            req_right_prev  <= on_ports.right_prev;
            req_right_next  <= on_ports.right_next;
            start           <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (costs_pending.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual cost %0d oor %0b",
                     $time, rsp_cost_half, rsp_out_of_range);
            mismatches++;
         end else begin
            due = costs_pending.pop_front();
            if (rsp_cost_half !== due.cost_half) begin
               $display("%0t: cost_half mismatch: expected %0d, actual %0d",
                        $time, due.cost_half, rsp_cost_half);
               mismatches++;
            end
            if (rsp_out_of_range !== due.out_of_range) begin
               $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                        $time, due.out_of_range, rsp_out_of_range);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items under the reset registers (width 640, max disparity 63)
      add_pair(0, 0, 0, 0, 0, 0, 0, 0);
      add_pair(63, 639, 255, 255, 255, 255, 255, 255);
      add_pair(0, 100, 0, 0, 0, 255, 255, 255);
      add_pair(0, 100, 255, 255, 255, 0, 0, 0);
      add_pair(64, 200, 10, 20, 30, 40, 50, 60);
      add_pair(255, 4095, 1, 2, 3, 4, 5, 6);
      add_pair(10, 9, 100, 100, 100, 100, 100, 100);
      add_pair(10, 10, 100, 100, 100, 120, 90, 140);
      add_pair(63, 63, 50, 50, 50, 90, 10, 95);
      add_pair(0, 639, 100, 100, 0, 130, 130, 255);
      add_pair(0, 0, 100, 0, 100, 130, 255, 130);
      add_pair(5, 4095, 40, 40, 40, 80, 80, 80);
      add_pair(61, 700, 200, 200, 200, 150, 150, 255);
      add_pair(3, 50, 100, 100, 100, 103, 103, 103);
      add_pair(3, 50, 100, 90, 110, 104, 80, 120);
      add_pair(8'h2a, 12'h555, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
      add_pair(8'h15, 12'haaa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa);
      add_pair(0, 1, 128, 0, 255, 127, 255, 0);
      add_pair(1, 1, 60, 200, 70, 20, 90, 30);
      settle();

      // random phases across register settings, one without gaps
      run_phase(2, 0, 100, 1'b1);
      run_phase(4096, 255, 200, 1'b0);
      run_phase(640, 63, 150, 1'b1);
      run_phase(1, 17, 60, 1'b1);
      run_phase(37, 200, 150, 1'b1);
      run_phase(4095, 128, 140, 1'b1);
      run_phase(100, 255, 150, 1'b1);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
